// File: rtl/ole_pkg.sv
package ole_pkg;

    // List geometry
    localparam int CAPACITY = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int SLOT_W   = $clog2(CAPACITY + 1);
    localparam int CNT_W    = SLOT_W;
    localparam int POS_W    = IDX_W;

    localparam logic [SLOT_W-1:0] NULL_SLOT = SLOT_W'(CAPACITY);

    // Field widths at the ports
    localparam int REQ_W       = 3;
    localparam int VAL_W       = 32;
    localparam int STATUS_W    = 2;
    localparam int FOUND_POS_W = 5;
    localparam int ELEM_CNT_W  = 6;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_INS_HEAD   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_INS_TAIL   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_INS_AFTER  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_INS_BEFORE = 3'd3;
    localparam logic [REQ_W-1:0] REQ_DELETE     = 3'd4;
    localparam logic [REQ_W-1:0] REQ_SEARCH     = 3'd5;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic [REQ_W-1:0]        req_type;
        logic signed [VAL_W-1:0] key_value;
        logic signed [VAL_W-1:0] target_value;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    pos;
        logic [CNT_W-1:0]    count;
    } res_t;

    // Write and read commands towards the slot store
    typedef struct packed {
        logic [IDX_W-1:0]        rd_addr;
        logic                    val_we;
        logic [IDX_W-1:0]        val_wa;
        logic signed [VAL_W-1:0] val_wd;
        logic                    nxt_we;
        logic [IDX_W-1:0]        nxt_wa;
        logic [SLOT_W-1:0]       nxt_wd;
        logic                    prv_we;
        logic [IDX_W-1:0]        prv_wa;
        logic [SLOT_W-1:0]       prv_wd;
        logic                    fre_we;
        logic [IDX_W-1:0]        fre_wa;
        logic [IDX_W-1:0]        fre_wd;
        logic [IDX_W-1:0]        fre_ra;
    } store_cmd_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] val;
        logic [SLOT_W-1:0]       nxt;
        logic [SLOT_W-1:0]       prv;
        logic [IDX_W-1:0]        fre;
    } store_rd_t;

endpackage

// File: rtl/ordered_list_engine.sv
// Channel   Direction  Ports           Word contents (lowest bit up)
// request   in         s_axis_*        tuser: req_type[2:0]
//                                      tdata: key_value[31:0], target_value[63:32]
// result    out        m_axis_*        tdata: status[1:0], found_position[6:2],
//                                             element_count[12:7], zero[15:13]
//
// A request runs from IDLE through START and ends in DONE; a full-list insert or an unused
// code goes straight to DONE. Insert at head or tail needs no walk of the list.
// Other requests walk from the head: one linked element a cycle through the single
// read port of the slot store, then inserts read the free slot in ALLOC and link in LINK1 and LINK2.
// Reset (aresetn low, synchronous) empties the list at once; store contents are kept.
// s_axis_tready is high only while idle; a finished result waits in the output register.
module ordered_list_engine
    import ole_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [2*VAL_W-1:0]     s_axis_tdata,   // key_value, target_value
    input  logic [REQ_W-1:0]       s_axis_tuser,   // req_type
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [15:0]            m_axis_tdata    // status, found_position, element_count
);

    localparam int RES_W = STATUS_W + FOUND_POS_W + ELEM_CNT_W;
    localparam int OUT_W = 16;

    req_t       req_in;
    res_t       res;
    logic       res_valid;
    logic       res_ack;
    store_cmd_t cmd;
    store_rd_t  rd;

    logic             out_valid_reg, out_valid_next;
    logic [OUT_W-1:0] out_data_reg, out_data_next;

    // unpack the request word
    assign req_in.req_type     = s_axis_tuser;
    assign req_in.key_value    = s_axis_tdata[VAL_W-1:0];
    assign req_in.target_value = s_axis_tdata[2*VAL_W-1:VAL_W];

    ole_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_axis_tvalid),
        .req_ready (s_axis_tready),
        .req_in    (req_in),
        .res_valid (res_valid),
        .res_ack   (res_ack),
        .res       (res),
        .cmd       (cmd),
        .rd        (rd)
    );

    ole_store u_store (
        .aclk (aclk),
        .cmd  (cmd),
        .rd   (rd)
    );

    // take the result whenever the output register is empty or draining
    assign res_ack = res_valid && (!out_valid_reg || m_axis_tready);

    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (res_ack) begin
            out_valid_next = 1'b1;
            out_data_next  = {(OUT_W - RES_W)'(0),
                              ELEM_CNT_W'(res.count),
                              FOUND_POS_W'(res.pos),
                              res.status};
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // drop ready for the whole of a request once its word is taken
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request accepted while previous one in progress");

    // the element count never exceeds the capacity
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[12:7] <= ELEM_CNT_W'(CAPACITY)))
        else $error("element count beyond capacity");

    // a rejected insert only happens on a full list and reports no position
    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && (m_axis_tdata[1:0] == ST_FULL)) |->
        ((m_axis_tdata[12:7] == ELEM_CNT_W'(CAPACITY)) && (m_axis_tdata[6:2] == '0)))
        else $error("full status on a list that is not full");

    // a miss reports position zero
    a_miss_position: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && (m_axis_tdata[1:0] == ST_NOT_FOUND)) |->
        (m_axis_tdata[6:2] == '0))
        else $error("not found status with a position");

endmodule

// File: rtl/ole_store.sv
module ole_store
    import ole_pkg::*;
(
    input  logic       aclk,
    input  store_cmd_t cmd,
    output store_rd_t  rd
);

    logic signed [VAL_W-1:0] val_mem [CAPACITY];
    logic [SLOT_W-1:0]       nxt_mem [CAPACITY];
    logic [SLOT_W-1:0]       prv_mem [CAPACITY];
    logic [IDX_W-1:0]        fre_mem [CAPACITY];   // stack of released slots

    store_rd_t rd_reg;

    always_ff @(posedge aclk) begin
        if (cmd.val_we) begin
            val_mem[cmd.val_wa] <= cmd.val_wd;
        end
        if (cmd.nxt_we) begin
            nxt_mem[cmd.nxt_wa] <= cmd.nxt_wd;
        end
        if (cmd.prv_we) begin
            prv_mem[cmd.prv_wa] <= cmd.prv_wd;
        end
        if (cmd.fre_we) begin
            fre_mem[cmd.fre_wa] <= cmd.fre_wd;
        end
        rd_reg.val <= val_mem[cmd.rd_addr];
        rd_reg.nxt <= nxt_mem[cmd.rd_addr];
        rd_reg.prv <= prv_mem[cmd.rd_addr];
        rd_reg.fre <= fre_mem[cmd.fre_ra];
    end

    assign rd = rd_reg;

endmodule

// File: rtl/ole_seq.sv
module ole_seq
    import ole_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       req_valid,
    output logic       req_ready,
    input  req_t       req_in,
    output logic       res_valid,
    input  logic       res_ack,
    output res_t       res,
    output store_cmd_t cmd,
    input  store_rd_t  rd
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_START = 8'b0000_0010,
        S_WALK  = 8'b0000_0100,
        S_DEL   = 8'b0000_1000,
        S_ALLOC = 8'b0001_0000,
        S_LINK1 = 8'b0010_0000,
        S_LINK2 = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [SLOT_W-1:0] head_reg, head_next;
    logic [SLOT_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0]  len_reg, len_next;
    logic [CNT_W-1:0]  fsp_reg, fsp_next;      // released slots on the stack
    logic [CNT_W-1:0]  fresh_reg, fresh_next;  // slots never yet handed out

    req_t                    req_reg, req_next;
    logic signed [VAL_W-1:0] cmp_reg, cmp_next;
    logic [SLOT_W-1:0]       cur_reg, cur_next;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic [STATUS_W-1:0]     status_reg, status_next;
    logic [SLOT_W-1:0]       m_nxt_reg, m_nxt_next;
    logic [SLOT_W-1:0]       m_prv_reg, m_prv_next;
    logic [SLOT_W-1:0]       s_reg, s_next;
    logic [SLOT_W-1:0]       p_reg, p_next;
    logic [SLOT_W-1:0]       n_reg, n_next;

    logic [CNT_W-1:0]  fsp_m1;
    logic [SLOT_W-1:0] new_slot;
    logic              is_insert;
    logic              val_eq;

    assign fsp_m1    = fsp_reg - CNT_W'(1);
    assign new_slot  = (fsp_reg != '0) ? SLOT_W'(rd.fre) : SLOT_W'(fresh_reg);
    assign is_insert = (req_reg.req_type == REQ_INS_HEAD) || (req_reg.req_type == REQ_INS_TAIL)
                    || (req_reg.req_type == REQ_INS_AFTER)
                    || (req_reg.req_type == REQ_INS_BEFORE);
    // the one shared compare unit
    assign val_eq    = (rd.val == cmp_reg);

    always_comb begin
        state_next  = state_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        len_next    = len_reg;
        fsp_next    = fsp_reg;
        fresh_next  = fresh_reg;
        req_next    = req_reg;
        cmp_next    = cmp_reg;
        cur_next    = cur_reg;
        pos_next    = pos_reg;
        status_next = status_reg;
        m_nxt_next  = m_nxt_reg;
        m_prv_next  = m_prv_reg;
        s_next      = s_reg;
        p_next      = p_reg;
        n_next      = n_reg;

        cmd         = '0;
        cmd.rd_addr = cur_reg[IDX_W-1:0];
        cmd.fre_ra  = fsp_m1[IDX_W-1:0];

        unique case (state_reg)
            S_IDLE: begin
                if (req_valid) begin
                    req_next    = req_in;
                    cmp_next    = ((req_in.req_type == REQ_INS_AFTER) ||
                                   (req_in.req_type == REQ_INS_BEFORE)) ?
                                  req_in.target_value : req_in.key_value;
                    pos_next    = '0;
                    status_next = ST_OK;
                    state_next  = S_START;
                end
            end
            S_START: begin
                if (req_reg.req_type > REQ_SEARCH) begin
                    state_next = S_DONE;
                end else if (is_insert && (len_reg == CNT_W'(CAPACITY))) begin
                    status_next = ST_FULL;
                    state_next  = S_DONE;
                end else if ((req_reg.req_type == REQ_INS_HEAD) ||
                             (req_reg.req_type == REQ_INS_TAIL)) begin
                    state_next = S_ALLOC;
                end else if (head_reg == NULL_SLOT) begin
                    status_next = ST_NOT_FOUND;
                    state_next  = S_DONE;
                end else begin
                    cmd.rd_addr = head_reg[IDX_W-1:0];
                    cur_next    = head_reg;
                    state_next  = S_WALK;
                end
            end
            S_WALK: begin
                if (val_eq) begin
                    m_nxt_next = rd.nxt;
                    m_prv_next = rd.prv;
                    if (req_reg.req_type == REQ_SEARCH) begin
                        state_next = S_DONE;
                    end else if (req_reg.req_type == REQ_DELETE) begin
                        state_next = S_DEL;
                    end else begin
                        state_next = S_ALLOC;
                    end
                end else if (rd.nxt == NULL_SLOT) begin
                    status_next = ST_NOT_FOUND;
                    pos_next    = '0;
                    state_next  = S_DONE;
                end else begin
                    cmd.rd_addr = rd.nxt[IDX_W-1:0];
                    cur_next    = rd.nxt;
                    pos_next    = pos_reg + POS_W'(1);
                end
            end
            S_DEL: begin
                if (m_prv_reg != NULL_SLOT) begin
                    cmd.nxt_we = 1'b1;
                    cmd.nxt_wa = m_prv_reg[IDX_W-1:0];
                    cmd.nxt_wd = m_nxt_reg;
                end else begin
                    head_next = m_nxt_reg;
                end
                if (m_nxt_reg != NULL_SLOT) begin
                    cmd.prv_we = 1'b1;
                    cmd.prv_wa = m_nxt_reg[IDX_W-1:0];
                    cmd.prv_wd = m_prv_reg;
                end else begin
                    tail_next = m_prv_reg;
                end
                cmd.fre_we = 1'b1;
                cmd.fre_wa = fsp_reg[IDX_W-1:0];
                cmd.fre_wd = cur_reg[IDX_W-1:0];
                fsp_next   = fsp_reg + CNT_W'(1);
                len_next   = len_reg - CNT_W'(1);
                state_next = S_DONE;
            end
            S_ALLOC: begin
                // let the registered free stack read settle before LINK1 uses it
                state_next = S_LINK1;
            end
            S_LINK1: begin
                priority if (req_reg.req_type == REQ_INS_HEAD) begin
                    p_next = NULL_SLOT;
                    n_next = head_reg;
                end else if (req_reg.req_type == REQ_INS_TAIL) begin
                    p_next = tail_reg;
                    n_next = NULL_SLOT;
                end else if (req_reg.req_type == REQ_INS_AFTER) begin
                    p_next = cur_reg;
                    n_next = m_nxt_reg;
                end else begin
                    p_next = m_prv_reg;
                    n_next = cur_reg;
                end
                s_next     = new_slot;
                cmd.val_we = 1'b1;
                cmd.val_wa = new_slot[IDX_W-1:0];
                cmd.val_wd = req_reg.key_value;
                cmd.nxt_we = 1'b1;
                cmd.nxt_wa = new_slot[IDX_W-1:0];
                cmd.nxt_wd = n_next;
                cmd.prv_we = 1'b1;
                cmd.prv_wa = new_slot[IDX_W-1:0];
                cmd.prv_wd = p_next;
                if (fsp_reg != '0) begin
                    fsp_next = fsp_m1;
                end else begin
                    fresh_next = fresh_reg + CNT_W'(1);
                end
                len_next   = len_reg + CNT_W'(1);
                state_next = S_LINK2;
            end
            S_LINK2: begin
                if (p_reg != NULL_SLOT) begin
                    cmd.nxt_we = 1'b1;
                    cmd.nxt_wa = p_reg[IDX_W-1:0];
                    cmd.nxt_wd = s_reg;
                end else begin
                    head_next = s_reg;
                end
                if (n_reg != NULL_SLOT) begin
                    cmd.prv_we = 1'b1;
                    cmd.prv_wa = n_reg[IDX_W-1:0];
                    cmd.prv_wd = s_reg;
                end else begin
                    tail_next = s_reg;
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                if (res_ack) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            head_reg  <= NULL_SLOT;
            tail_reg  <= NULL_SLOT;
            len_reg   <= '0;
            fsp_reg   <= '0;
            fresh_reg <= '0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            len_reg   <= len_next;
            fsp_reg   <= fsp_next;
            fresh_reg <= fresh_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg    <= req_next;
        cmp_reg    <= cmp_next;
        cur_reg    <= cur_next;
        pos_reg    <= pos_next;
        status_reg <= status_next;
        m_nxt_reg  <= m_nxt_next;
        m_prv_reg  <= m_prv_next;
        s_reg      <= s_next;
        p_reg      <= p_next;
        n_reg      <= n_next;
    end

    assign req_ready  = (state_reg == S_IDLE);
    assign res_valid  = (state_reg == S_DONE);
    assign res.status = status_reg;
    assign res.pos    = pos_reg;
    assign res.count  = len_reg;

endmodule
